>>> rtl/software_timer_list_defines.svh
// Assertion macros used by the timer list checker.
`ifndef SOFTWARE_TIMER_LIST_DEFINES_SVH
`define SOFTWARE_TIMER_LIST_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define STL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer list check failed in %m");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define STL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer list check failed in %m");

`endif

>>> rtl/stl_pkg.sv
// Shared types, sizes and codes of the software timer list.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TICK_BITS  = 16;

  localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int LINK_W = $clog2(NUM_TIMERS + 1);

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_TIMERS);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_INIT  = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } stl_op_e;

  typedef struct packed {
    stl_op_e     opcode;
    logic [3:0]  timer_index;
    logic [15:0] ticks;
    logic [15:0] period;
    logic [7:0]  event_code;
    logic [5:0]  target_id;
  } stl_in_t;

  typedef struct packed {
    logic [3:0] expired_timer;
    logic [7:0] expired_event;
    logic [5:0] expired_target;
    logic       last;
  } stl_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic apply_op;
    logic walk_start;
    logic walk_step;
    logic flush;
  } stl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic step_ok;
    logic pend_valid;
    logic flush_ok;
  } stl_sts_t;

endpackage

`default_nettype wire

>>> rtl/stl_if.sv
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps
`default_nettype none

interface stl_in_if import stl_pkg::*; ();
  logic    valid;
  logic    ready;
  stl_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stl_out_if import stl_pkg::*; ();
  logic     valid;
  logic     ready;
  stl_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/stl_datapath.sv
// Timer storage, list walk registers, pending result and output register.
`timescale 1ns / 1ps
`default_nettype none

module stl_datapath import stl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stl_in_t       in_data_i,
  input  stl_cmd_t      cmd_i,
  output stl_sts_t      sts_o,
  stl_out_if.source     out_o
);

  // Timer state
  logic [LINK_W-1:0]    next_link_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] in_list_q;
  logic [TICK_BITS-1:0] remaining_q [NUM_TIMERS];
  logic [TICK_BITS-1:0] reload_q    [NUM_TIMERS];
  logic [7:0]           event_q     [NUM_TIMERS];
  logic [5:0]           receiver_q  [NUM_TIMERS];
  logic [LINK_W-1:0]    head_q;

  // Walk registers
  logic [LINK_W-1:0]    cur_q;
  logic [LINK_W-1:0]    prev_q;
  logic [LINK_W-1:0]    visits_q;

  // Pending result and output register
  logic                 pend_valid_q;
  logic [3:0]           pend_timer_q;
  logic [7:0]           pend_event_q;
  logic [5:0]           pend_target_q;
  logic                 out_valid_q;
  stl_out_t             out_data_q;

  logic [IDX_W-1:0]     op_idx;
  logic                 idx_ok;
  logic [TICK_BITS-1:0] op_ticks;
  logic [TICK_BITS-1:0] op_period;
  logic                 start_ok;

  logic [IDX_W-1:0]     cur_idx;
  logic [IDX_W-1:0]     prev_idx;
  logic [TICK_BITS-1:0] cur_rem;
  logic [TICK_BITS-1:0] rem_dec;
  logic [LINK_W-1:0]    cur_next;
  logic                 rem_zero;
  logic                 dec_zero;
  logic                 reload_zero;
  logic                 expire;
  logic                 do_unlink;
  logic                 keep;
  logic                 load_out;

  // Decode the addressed timer of an operation
  assign op_idx    = IDX_W'(in_data_i.timer_index);
  assign idx_ok    = 32'(in_data_i.timer_index) < 32'(NUM_TIMERS);
  assign op_ticks  = TICK_BITS'(in_data_i.ticks);
  assign op_period = TICK_BITS'(in_data_i.period);
  assign start_ok  = op_ticks != '0;

  // Evaluate the entry under the walk pointer
  assign cur_idx     = cur_q[IDX_W-1:0];
  assign prev_idx    = prev_q[IDX_W-1:0];
  assign cur_rem     = remaining_q[cur_idx];
  assign cur_next    = next_link_q[cur_idx];
  assign rem_dec     = cur_rem - TICK_BITS'(1);
  assign rem_zero    = cur_rem == '0;
  assign dec_zero    = rem_dec == '0;
  assign reload_zero = reload_q[cur_idx] == '0;
  assign expire      = cmd_i.walk_step && !rem_zero && dec_zero;
  assign do_unlink   = cmd_i.walk_step && (rem_zero || (dec_zero && reload_zero));
  assign keep        = cmd_i.walk_step && !do_unlink;
  assign load_out    = (expire && pend_valid_q) || cmd_i.flush;

  // Report walk and output status
  assign sts_o.walk_done  = (cur_q >= NULL_LINK) || (visits_q == LINK_W'(NUM_TIMERS));
  assign sts_o.step_ok    = !pend_valid_q || !out_valid_q || out_o.ready;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.flush_ok   = !out_valid_q || out_o.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Update timer state, list head and walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        remaining_q[i] <= '0;
        reload_q[i]    <= '0;
        event_q[i]     <= '0;
        receiver_q[i]  <= '0;
      end
      in_list_q    <= '0;
      head_q       <= NULL_LINK;
      cur_q        <= NULL_LINK;
      prev_q       <= NULL_LINK;
      visits_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.apply_op && idx_ok) begin
        unique case (in_data_i.opcode)
          OP_INIT: begin
            event_q[op_idx]     <= in_data_i.event_code;
            remaining_q[op_idx] <= '0;
          end
          OP_START: begin
            if (start_ok) begin
              receiver_q[op_idx]  <= in_data_i.target_id;
              remaining_q[op_idx] <= op_ticks;
              reload_q[op_idx]    <= op_period;
              if (!in_list_q[op_idx]) begin
                in_list_q[op_idx] <= 1'b1;
                head_q            <= LINK_W'(op_idx);
              end
            end
          end
          OP_STOP: begin
            remaining_q[op_idx] <= '0;
          end
          default: begin
          end
        endcase
      end

      if (cmd_i.walk_start) begin
        cur_q        <= head_q;
        prev_q       <= NULL_LINK;
        visits_q     <= '0;
        pend_valid_q <= 1'b0;
      end

      // Advance one list entry
      if (cmd_i.walk_step) begin
        cur_q    <= cur_next;
        visits_q <= visits_q + LINK_W'(1);
        if (!rem_zero) begin
          remaining_q[cur_idx] <= (dec_zero && !reload_zero) ? reload_q[cur_idx] : rem_dec;
        end
        if (do_unlink) begin
          in_list_q[cur_idx] <= 1'b0;
          if (prev_q == NULL_LINK) begin
            head_q <= cur_next;
          end
        end
        if (keep) begin
          prev_q <= cur_q;
        end
        if (expire) begin
          pend_valid_q <= 1'b1;
        end
      end

      if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end

      // Hold the result until taken
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Write links and result payloads
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply_op && idx_ok && in_data_i.opcode == OP_START && start_ok &&
        !in_list_q[op_idx]) begin
      next_link_q[op_idx] <= head_q;
    end
    if (do_unlink && prev_q != NULL_LINK) begin
      next_link_q[prev_idx] <= cur_next;
    end
    if (expire) begin
      pend_timer_q  <= 4'(cur_idx);
      pend_event_q  <= event_q[cur_idx];
      pend_target_q <= receiver_q[cur_idx];
    end
    if (load_out) begin
      out_data_q.expired_timer  <= pend_timer_q;
      out_data_q.expired_event  <= pend_event_q;
      out_data_q.expired_target <= pend_target_q;
      out_data_q.last           <= cmd_i.flush;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stl_ctrl.sv
// Controller: accepts items and sequences the list walk of a tick.
`timescale 1ns / 1ps
`default_nettype none

module stl_ctrl import stl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  stl_op_e  in_opcode_i,
  output logic     in_ready_o,
  input  stl_sts_t sts_i,
  output stl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  state_e state_q;
  state_e state_d;

  // Decode commands and next state
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == OP_TICK) begin
            cmd_o.walk_start = 1'b1;
            state_d          = ST_WALK;
          end else begin
            cmd_o.apply_op = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (sts_i.walk_done) begin
          state_d = sts_i.pend_valid ? ST_FLUSH : ST_IDLE;
        end else begin
          cmd_o.walk_step = sts_i.step_ok;
        end
      end
      ST_FLUSH: begin
        if (sts_i.flush_ok) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/software_timer_list.sv
// Init, start and stop are applied when accepted; ready stays high between them.
// A tick visits the listed timers in list order (at most NUM_TIMERS), then finishes,
// and flushes a final result to the output when one is pending.
// New items wait until the tick is done, since there is a single walk pointer;
// a step that must move a result waits while the output is stalled.
// Reset (async, active low) empties the list and clears all counts, bindings and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module software_timer_list import stl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  stl_in_if.sink     in_i,
  stl_out_if.source  out_o
);

  stl_cmd_t cmd;
  stl_sts_t sts;
  logic     in_ready;

  assign in_i.ready = in_ready;

  // Sequence operations and walks
  stl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.data.opcode),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Store timers and produce results
  stl_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_i.data),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

>>> rtl/stl_checker.sv
// Port-level checks of the timer list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "software_timer_list_defines.svh"

module stl_checker import stl_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input stl_op_e    in_opcode_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input stl_out_t   out_data_i
);

  // A tick blocks new items while the list is walked
  `STL_ASSERT_NEXT(a_tick_busy, clk_i, rst_ni, in_valid_i && in_ready_i && in_opcode_i == OP_TICK, !in_ready_i)

  // Operations other than tick never produce a result
  `STL_ASSERT_NEXT(a_op_silent, clk_i, rst_ni, in_valid_i && in_ready_i && in_opcode_i != OP_TICK && !out_valid_i, !out_valid_i)

  // A stalled result stays offered
  `STL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // A stalled result keeps its payload
  `STL_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i))

endmodule

bind software_timer_list stl_checker u_stl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_opcode_i (in_i.data.opcode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

>>> tb/software_timer_list_tb.sv
// Self-checking testbench for the software timer list: directed table, then random operations.
`timescale 1ns / 1ps

module software_timer_list_tb;
  import stl_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 2 * NUM_TIMERS + 8;
  localparam int RAND_PER_PHASE = 40;

  // One row of the directed table; typed rows carry their expectation inline.
  typedef struct {
    stl_in_t  item;
    bit       typed;
    bit       has_res;
    stl_out_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  stl_in_if  in_if ();
  stl_out_if out_if ();

  software_timer_list dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the timer bank
  logic [LINK_W-1:0]    tl_head = NULL_LINK;
  logic [LINK_W-1:0]    tl_link   [NUM_TIMERS];
  bit                   tl_listed [NUM_TIMERS];
  logic [TICK_BITS-1:0] tl_count  [NUM_TIMERS];
  logic [TICK_BITS-1:0] tl_reload [NUM_TIMERS];
  logic [7:0]           tl_event  [NUM_TIMERS];
  logic [5:0]           tl_rcv    [NUM_TIMERS];

  stl_out_t tick_hits [$];
  stl_out_t expiry_q  [$];
  dir_row_t dir_tab   [$];

  int send_idle  = 0;
  int recv_stall = 0;
  int err_count  = 0;
  int cycle_cnt  = 0;

  initial begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tl_link[i]   = NULL_LINK;
      tl_listed[i] = 1'b0;
      tl_count[i]  = '0;
      tl_reload[i] = '0;
      tl_event[i]  = '0;
      tl_rcv[i]    = '0;
    end
  end

  function automatic void drop_timer(input logic [LINK_W-1:0] cur,
                                     input logic [LINK_W-1:0] prev);
    if (prev == NULL_LINK) tl_head = tl_link[cur];
    else tl_link[prev] = tl_link[cur];
    tl_listed[cur] = 1'b0;
  endfunction

  // Walk the shadow list once; collect expiries in list order
  function automatic void walk_tick();
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] nxt;
    int                visits;
    bit                pending;
    stl_out_t          held;
    prev    = NULL_LINK;
    cur     = tl_head;
    visits  = 0;
    pending = 1'b0;
    held    = '0;
    while (cur < NUM_TIMERS && visits < NUM_TIMERS) begin
      nxt = tl_link[cur];
      visits++;
      if (tl_count[cur] == '0) begin
        drop_timer(cur, prev);
      end else begin
        tl_count[cur] = tl_count[cur] - 1'b1;
        if (tl_count[cur] == '0) begin
          // hold each hit back one step so the final one can be flagged
          if (pending) tick_hits.push_back(held);
          held.expired_timer  = cur[3:0];
          held.expired_event  = tl_event[cur];
          held.expired_target = tl_rcv[cur];
          held.last           = 1'b0;
          pending             = 1'b1;
          if (tl_reload[cur] == '0) begin
            drop_timer(cur, prev);
          end else begin
            tl_count[cur] = tl_reload[cur];
            prev          = cur;
          end
        end else begin
          prev = cur;
        end
      end
      cur = nxt;
    end
    if (pending) begin
      held.last = 1'b1;
      tick_hits.push_back(held);
    end
  endfunction

  // Advance the shadow bank by one item; expiries land in tick_hits
  function automatic void timer_update(input stl_in_t it);
    logic [IDX_W-1:0] t;
    tick_hits.delete();
    if (it.opcode == OP_TICK) begin
      walk_tick();
      return;
    end
    if (it.timer_index >= NUM_TIMERS) return;
    t = it.timer_index[IDX_W-1:0];
    case (it.opcode)
      OP_INIT: begin
        tl_event[t] = it.event_code;
        tl_count[t] = '0;
      end
      OP_START: begin
        if (it.ticks != '0) begin
          tl_rcv[t]    = it.target_id;
          tl_count[t]  = it.ticks;
          tl_reload[t] = it.period;
          if (!tl_listed[t]) begin
            tl_link[t]   = tl_head;
            tl_head      = LINK_W'(t);
            tl_listed[t] = 1'b1;
          end
        end
      end
      default: tl_count[t] = '0;
    endcase
  endfunction

  function automatic dir_row_t mk_row(input stl_op_e op, input int idx, input int tk,
                                      input int per, input int ev, input int tgt,
                                      input bit typed = 1'b0, input bit has = 1'b0,
                                      input int xt = 0, input int xe = 0, input int xg = 0);
    dir_row_t r;
    r.item.opcode          = op;
    r.item.timer_index     = 4'(idx);
    r.item.ticks           = 16'(tk);
    r.item.period          = 16'(per);
    r.item.event_code      = 8'(ev);
    r.item.target_id       = 6'(tgt);
    r.typed                = typed;
    r.has_res              = has;
    r.res.expired_timer    = 4'(xt);
    r.res.expired_event    = 8'(xe);
    r.res.expired_target   = 6'(xg);
    r.res.last             = has;
    return r;
  endfunction

  // Present one item, hold it until accepted, then record what it should cause
  task automatic issue_item(input stl_in_t it, input bit typed = 1'b0,
                            input bit has_res = 1'b0, input stl_out_t res = '0);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    timer_update(it);
    if (typed) begin
      if (has_res) expiry_q.push_back(res);
    end else begin
      foreach (tick_hits[k]) expiry_q.push_back(tick_hits[k]);
    end
  endtask

  task automatic check_expiry(input stl_out_t got);
    stl_out_t want;
    if (expiry_q.size() == 0) begin
      err_count++;
      if (err_count <= 10)
        $display("unexpected expiry: timer %0d event 0x%02h target %0d last %0b",
                 got.expired_timer, got.expired_event, got.expired_target, got.last);
      return;
    end
    want = expiry_q.pop_front();
    if (got.expired_timer !== want.expired_timer || got.expired_event !== want.expired_event ||
        got.expired_target !== want.expired_target || got.last !== want.last) begin
      err_count++;
      if (err_count <= 10)
        $display("expiry mismatch: expected timer %0d event 0x%02h target %0d last %0b, got timer %0d event 0x%02h target %0d last %0b",
                 want.expired_timer, want.expired_event, want.expired_target, want.last,
                 got.expired_timer, got.expired_event, got.expired_target, got.last);
    end
  endtask

  // Check each accepted result, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) check_expiry(out_if.data);
    out_if.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("software_timer_list_tb NOT OK");
      $finish;
    end
  end

  initial begin
    stl_in_t it;
    int      r;
    int      idle_tab  [4];
    int      stall_tab [4];
    idle_tab     = '{0, 88, 0, 26};
    stall_tab    = '{0, 0, 88, 26};
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;

    // tick on an empty bank, start with zero ticks, one-shot at the top index
    dir_tab.push_back(mk_row(OP_TICK,   0, 0, 0, 0, 0, 1'b1));
    dir_tab.push_back(mk_row(OP_INIT,   0, 0, 0, 8'hFF, 0, 1'b1));
    dir_tab.push_back(mk_row(OP_START,  0, 0, 5, 0, 63, 1'b1));
    dir_tab.push_back(mk_row(OP_TICK,   0, 0, 0, 0, 0, 1'b1));
    dir_tab.push_back(mk_row(OP_START, 15, 1, 0, 0, 63, 1'b1));
    dir_tab.push_back(mk_row(OP_TICK,   0, 0, 0, 0, 0, 1'b1, 1'b1, 15, 0, 63));
    dir_tab.push_back(mk_row(OP_TICK,   0, 0, 0, 0, 0, 1'b1));
    dir_tab.push_back(mk_row(OP_INIT,  15, 0, 0, 8'hA5, 0, 1'b1));
    // largest count and period, periodic reload, restart of a listed timer
    dir_tab.push_back(mk_row(OP_START,  0, 16'hFFFF, 16'hFFFF, 0, 0, 1'b1));
    dir_tab.push_back(mk_row(OP_START,  3, 2, 1, 8'hFF, 21));
    dir_tab.push_back(mk_row(OP_TICK,   0, 16'hFFFF, 16'hFFFF, 8'hFF, 63));
    dir_tab.push_back(mk_row(OP_TICK,   0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_START,  3, 1, 0, 0, 42));
    dir_tab.push_back(mk_row(OP_STOP,   0, 16'hFFFF, 16'hFFFF, 8'hFF, 63));
    dir_tab.push_back(mk_row(OP_TICK,   0, 0, 0, 0, 0));
    // several expiries in one tick, init on a listed timer
    dir_tab.push_back(mk_row(OP_START,  7, 1, 3, 0, 7));
    dir_tab.push_back(mk_row(OP_START,  8, 1, 0, 0, 8));
    dir_tab.push_back(mk_row(OP_START,  9, 3, 0, 0, 9));
    dir_tab.push_back(mk_row(OP_INIT,   9, 0, 0, 8'h5A, 0));
    dir_tab.push_back(mk_row(OP_TICK,   0, 0, 0, 0, 0));
    // stop on an unlisted timer, then a long-period timer
    dir_tab.push_back(mk_row(OP_STOP,  12, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_START, 12, 2, 16'hFFFF, 0, 12));
    dir_tab.push_back(mk_row(OP_TICK,   0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_TICK,   0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(OP_TICK,   0, 0, 0, 0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      issue_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].has_res, dir_tab[i].res);

    // Random operations, mostly short starts so timers keep expiring
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = idle_tab[ph];
      recv_stall = stall_tab[ph];
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        it.timer_index = 4'($urandom_range(15));
        it.ticks       = 16'($urandom);
        it.period      = 16'($urandom);
        it.event_code  = 8'($urandom);
        it.target_id   = 6'($urandom);
        r = $urandom_range(99);
        if (r < 30) begin
          it.opcode = OP_TICK;
        end else if (r < 70) begin
          it.opcode = OP_START;
          r = $urandom_range(99);
          if (r < 85) it.ticks = 16'($urandom_range(4, 1));
          else if (r < 90) it.ticks = '0;
          r = $urandom_range(99);
          if (r < 40) it.period = '0;
          else if (r < 85) it.period = 16'($urandom_range(4, 1));
        end else if (r < 85) begin
          it.opcode = OP_INIT;
        end else begin
          it.opcode = OP_STOP;
        end
        issue_item(it);
      end
    end
    in_if.valid <= 1'b0;

    // Drain outstanding expiries, then give the walker time to settle
    while (expiry_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("software_timer_list_tb OK");
    end else begin
      $display("software_timer_list_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/stl_pkg.sv
rtl/stl_if.sv
rtl/stl_datapath.sv
rtl/stl_ctrl.sv
rtl/software_timer_list.sv
rtl/stl_checker.sv
tb/software_timer_list_tb.sv
